@@ hdl/acs_pkg.sv @@
// Shared types, constants and opcodes for the accumulator machine step block.
`default_nettype none

package acs_pkg;

   localparam int ADDR_BITS = 12;
   localparam int WORD_BITS = 16;
   localparam int OP_BITS   = 4;
   localparam int SEL_BITS  = 2;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WORD_BITS-1:0] word_type;

   // Request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EXEC = 1'b1;

   typedef enum logic [OP_BITS-1:0] {
      OP_JNS    = 4'h0,
      OP_LOAD   = 4'h1,
      OP_STORE  = 4'h2,
      OP_ADD    = 4'h3,
      OP_SUBT   = 4'h4,
      OP_INPUT  = 4'h5,
      OP_OUTPUT = 4'h6,
      OP_HALT   = 4'h7,
      OP_SKIP   = 4'h8,
      OP_JUMP   = 4'h9,
      OP_CLEAR  = 4'hA,
      OP_ADDI   = 4'hB,
      OP_JUMPI  = 4'hC,
      OP_LOADI  = 4'hD,
      OP_STOREI = 4'hE,
      OP_NOP    = 4'hF
   } opcode_type;

   // SKIPCOND selectors (the top two bits of the address field)
   localparam logic [SEL_BITS-1:0] SKIP_NEG  = 2'b00;
   localparam logic [SEL_BITS-1:0] SKIP_ZERO = 2'b01;
   localparam logic [SEL_BITS-1:0] SKIP_POS  = 2'b10;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_FETCH,
      S_DECODE,
      S_EXEC,
      S_INDIR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic     req_type;
      addr_type load_addr;
      word_type load_word;
      word_type input_value;
   } req_item_type;

   typedef struct packed {
      logic     out_valid;
      word_type out_value;
      logic     input_taken;
      logic     halted_flag;
      addr_type pc_now;
      word_type acc_now;
   } rsp_item_type;

   typedef struct packed {
      logic     we;
      addr_type addr;
      word_type wdata;
   } mem_req_type;

   typedef struct packed {
      word_type a;
      word_type b;
      logic     sub;
   } alu_op_type;

   typedef struct packed {
      logic ready;
      logic done;
   } core_stat_type;

endpackage

`default_nettype wire

@@ hdl/acs_alu.sv @@
// Shared adder/subtractor used for PC, address and accumulator arithmetic.
`default_nettype none

module acs_alu import acs_pkg::*; (
   input  alu_op_type alu_op,
   output word_type   alu_sum
);

   always_comb begin
      if (alu_op.sub) begin
         alu_sum = alu_op.a - alu_op.b;
      end else begin
         alu_sum = alu_op.a + alu_op.b;
      end
   end

endmodule

`default_nettype wire

@@ hdl/acs_mem.sv @@
// Single-port main memory with registered read data.
`default_nettype none

module acs_mem import acs_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output word_type    mem_rdata
);

   word_type mem_ff [MEM_DEPTH];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.addr] <= mem_req.wdata;
      end else begin
         rdata_ff <= mem_ff[mem_req.addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hdl/acs_core.sv @@
// Sequencer and registers: memory clear, program load and instruction execution.
`default_nettype none

module acs_core import acs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  req_item_type  req_item,
   input  logic          rsp_free,
   input  word_type      mem_rdata,
   output mem_req_type   mem_req,
   output core_stat_type core_stat,
   output rsp_item_type  rsp_item
);

   state_type    state_ff, state_in;
   addr_type     clr_ff, clr_in;
   addr_type     pc_ff, pc_in;
   word_type     acc_ff, acc_in;
   word_type     ir_ff, ir_in;
   logic         halt_ff, halt_in;
   logic         outv_ff, outv_in;
   logic         intk_ff, intk_in;
   req_item_type req_ff, req_in;

   alu_op_type   alu_op;
   word_type     alu_sum;
   opcode_type   op;
   addr_type     x_addr;
   addr_type     ind_addr;
   logic [SEL_BITS-1:0] sel;
   logic         skip;

   acs_alu u_alu (
      .alu_op  (alu_op),
      .alu_sum (alu_sum)
   );

   assign op       = opcode_type'(ir_ff[WORD_BITS-1 -: OP_BITS]);
   assign x_addr   = ir_ff[ADDR_BITS-1:0];
   assign ind_addr = mem_rdata[ADDR_BITS-1:0];
   assign sel      = ir_ff[ADDR_BITS-1 -: SEL_BITS];

   always_comb begin
      case (sel)
         SKIP_NEG:  skip = acc_ff[WORD_BITS-1];
         SKIP_ZERO: skip = (acc_ff == '0);
         SKIP_POS:  skip = (acc_ff != '0) && !acc_ff[WORD_BITS-1];
         default:   skip = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_item.req_type == REQ_LOAD) begin
                  state_in = S_LOAD;
               end else if (halt_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_LOAD:   state_in = S_DONE;
         S_FETCH:  state_in = S_DECODE;
         S_DECODE: state_in = S_EXEC;
         S_EXEC: begin
            if (op == OP_ADDI || op == OP_LOADI) begin
               state_in = S_INDIR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INDIR: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // datapath control
   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.addr  = pc_ff;
      mem_req.wdata = '0;
      alu_op.a      = WORD_BITS'(pc_ff);
      alu_op.b      = WORD_BITS'(1);
      alu_op.sub    = 1'b0;
      clr_in        = clr_ff;
      pc_in         = pc_ff;
      acc_in        = acc_ff;
      ir_in         = ir_ff;
      halt_in       = halt_ff;
      outv_in       = outv_ff;
      intk_in       = intk_ff;
      req_in        = req_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_ff;
            clr_in       = ADDR_BITS'(clr_ff + 1'b1);
         end
         S_IDLE: begin
            if (req_fire) begin
               req_in  = req_item;
               outv_in = 1'b0;
               intk_in = 1'b0;
            end
         end
         S_LOAD: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = req_ff.load_addr;
            mem_req.wdata = req_ff.load_word;
         end
         S_FETCH: begin
            mem_req.addr = pc_ff;
         end
         S_DECODE: begin
            ir_in        = mem_rdata;
            pc_in        = alu_sum[ADDR_BITS-1:0];
            mem_req.addr = ind_addr;
         end
         S_EXEC: begin
            case (op)
               OP_JNS: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = x_addr;
                  mem_req.wdata = WORD_BITS'(pc_ff);
                  alu_op.a      = WORD_BITS'(x_addr);
                  pc_in         = alu_sum[ADDR_BITS-1:0];
               end
               OP_LOAD: acc_in = mem_rdata;
               OP_STORE: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = x_addr;
                  mem_req.wdata = acc_ff;
               end
               OP_ADD, OP_SUBT: begin
                  alu_op.a   = acc_ff;
                  alu_op.b   = mem_rdata;
                  alu_op.sub = (op == OP_SUBT);
                  acc_in     = alu_sum;
               end
               OP_INPUT: begin
                  acc_in  = req_ff.input_value;
                  intk_in = 1'b1;
               end
               OP_OUTPUT: outv_in = 1'b1;
               OP_HALT:   halt_in = 1'b1;
               OP_SKIP: begin
                  if (skip) pc_in = alu_sum[ADDR_BITS-1:0];
               end
               OP_JUMP:  pc_in = x_addr;
               OP_CLEAR: acc_in = '0;
               OP_ADDI, OP_LOADI: begin
                  mem_req.addr = ind_addr;
               end
               OP_JUMPI: pc_in = ind_addr;
               OP_STOREI: begin
                  mem_req.we    = 1'b1;
                  mem_req.addr  = ind_addr;
                  mem_req.wdata = acc_ff;
               end
               default: begin
               end
            endcase
         end
         S_INDIR: begin
            if (op == OP_ADDI) begin
               alu_op.a = acc_ff;
               alu_op.b = mem_rdata;
               acc_in   = alu_sum;
            end else begin
               acc_in = mem_rdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pc_ff    <= '0;
         acc_ff   <= '0;
         halt_ff  <= 1'b0;
         outv_ff  <= 1'b0;
         intk_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         halt_ff  <= halt_in;
         outv_ff  <= outv_in;
         intk_ff  <= intk_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_ff  <= ir_in;
      req_ff <= req_in;
   end

   assign core_stat.ready = (state_ff == S_IDLE);
   assign core_stat.done  = (state_ff == S_DONE);

   assign rsp_item.out_valid   = outv_ff;
   assign rsp_item.out_value   = outv_ff ? acc_ff : '0;
   assign rsp_item.input_taken = intk_ff;
   assign rsp_item.halted_flag = halt_ff;
   assign rsp_item.pc_now      = pc_ff;
   assign rsp_item.acc_now     = acc_ff;

   a_fetch_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> !mem_req.we)
      else $error("memory write during instruction fetch");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt state cleared without reset");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("transfer accepted but sequencer stayed idle");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> state_ff == S_IDLE)
      else $error("result handed off but sequencer did not return to idle");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_fire) |=> ($stable(pc_ff) && $stable(acc_ff)))
      else $error("machine registers changed while idle");

endmodule

`default_nettype wire

@@ hdl/accumulator_cpu_step.sv @@
// Top level of the accumulator machine step block: handshakes, result register, memory.
//
//   port group   direction   payload          handshake
//   req_*        in          req_item_type    req_valid / req_stall
//   rsp_*        out         rsp_item_type    rsp_valid / rsp_stall
//
// A load transfer passes through the LOAD and DONE states after acceptance; an
// instruction through FETCH, DECODE, EXEC and DONE (plus INDIR for ADDI and LOADI,
// one extra indirect read; straight to DONE once halted), one single-port memory
// access per cycle setting the pace; idle is re-entered before the next transfer.
// After reset a clearing pass zeroes all 4096 memory words, one per cycle;
// req_stall stays high until the pass is done.
// A finished result waits in the output register under rsp_stall while the
// next item is already accepted and worked on.
`default_nettype none

module accumulator_cpu_step import acs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   core_stat_type core_stat;
   mem_req_type   mem_req;
   word_type      mem_rdata;
   rsp_item_type  core_rsp;
   logic          req_fire;
   logic          rsp_free;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_data_ff, rsp_data_in;

   assign req_stall = !core_stat.ready;
   assign req_fire  = req_valid && core_stat.ready;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   acs_mem u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   acs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_data),
      .rsp_free  (rsp_free),
      .mem_rdata (mem_rdata),
      .mem_req   (mem_req),
      .core_stat (core_stat),
      .rsp_item  (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_stat.done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
